>>> hdl/pmdg_pkg.sv
// package for the particle mass deposit grid
// holds sizes, payload structs and the front to back queue word type
package pmdg_pkg;
    localparam int GRID_SIDE = 64;
    localparam int FRAC_BITS = 16;
    localparam int WBITS = 16;
    localparam int SIDE_W = $clog2(GRID_SIDE);
    localparam int ADDR_W = 3 * SIDE_W;
    localparam int NCELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int POS_W = 23;
    localparam int W_W = WBITS + 1;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic KIND_DEPOSIT = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [22:0] pos_x;
        logic [22:0] pos_y;
        logic [22:0] pos_z;
        logic [31:0] particle_mass;
        logic [17:0] cell_index;
    } t_in_word;

    typedef struct packed {
        logic [47:0] cell_mass;
        logic [47:0] total_mass;
    } t_out_word;

    typedef struct packed {
        logic              rd;
        logic [17:0]       idx;
        logic [31:0]       mass;
        logic [SIDE_W-1:0] hx, hy, hz;
        logic [W_W-1:0]    wx0, wx1, wx2, wy0, wy1, wy2, wz0, wz1, wz2;
    } t_job;
endpackage

>>> hdl/pmdg_front.sv
// front end: accepts words, finds home cells and 1-d weights per axis
// depends on pmdg_pkg
module pmdg_front import pmdg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_scheme,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_word,
    output logic     o_valid,
    input  logic     i_ready,
    output t_job     o_job
);
    logic r_v;
    t_job r_job, n_job;
    logic [SIDE_W-1:0] hx, hy, hz;
    logic [W_W-1:0] w[3][3];

    function automatic logic [W_W-1:0] rq(input logic [2*FRAC_BITS+1:0] v, input logic tsc);
        logic [2*FRAC_BITS+2:0] t;
        begin
            if (tsc) begin
                t = {1'b0, v} + ((2*FRAC_BITS+3)'(1) << (2*FRAC_BITS - WBITS));
                rq = W_W'(t >> (2*FRAC_BITS + 1 - WBITS));
            end else begin
                rq = W_W'(v);
            end
        end
    endfunction

    task automatic axis(input logic [POS_W-1:0] p, input logic tsc,
                        output logic [SIDE_W-1:0] h, output logic [W_W-1:0] w0,
                        output logic [W_W-1:0] w1, output logic [W_W-1:0] w2);
        logic [FRAC_BITS:0] fr, a, lo, hi, half;
        logic neg;
        logic [2*FRAC_BITS+1:0] l2, h2, c2;
        begin
            half = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
            if (p >= POS_W'(GRID_SIDE) << FRAC_BITS) begin
                h = SIDE_W'(GRID_SIDE - 1);
                fr = (FRAC_BITS+1)'(1) << FRAC_BITS;
            end else begin
                h = SIDE_W'(p >> FRAC_BITS);
                fr = (FRAC_BITS+1)'(p[FRAC_BITS-1:0]);
            end
            neg = fr < half;
            a = neg ? half - fr : fr - half;
            lo = neg ? half + a : half - a;
            hi = neg ? half - a : half + a;
            l2 = (2*FRAC_BITS+2)'(lo) * (2*FRAC_BITS+2)'(lo);
            h2 = (2*FRAC_BITS+2)'(hi) * (2*FRAC_BITS+2)'(hi);
            c2 = ((2*FRAC_BITS+2)'(3) << (2*FRAC_BITS - 1))
                 - (((2*FRAC_BITS+2)'(a) * (2*FRAC_BITS+2)'(a)) << 1);
            if (tsc) begin
                w0 = rq(l2, 1'b1);
                w1 = rq(c2, 1'b1);
                w2 = rq(h2, 1'b1);
            end else begin
                w0 = W_W'((neg ? a : '0) << (WBITS - FRAC_BITS));
                w1 = W_W'((((FRAC_BITS+1)'(1) << FRAC_BITS) - a) << (WBITS - FRAC_BITS));
                w2 = W_W'((neg ? '0 : a) << (WBITS - FRAC_BITS));
            end
        end
    endtask

    always_comb begin
        axis(i_word.pos_x, i_scheme, hx, w[0][0], w[0][1], w[0][2]);
        axis(i_word.pos_y, i_scheme, hy, w[1][0], w[1][1], w[1][2]);
        axis(i_word.pos_z, i_scheme, hz, w[2][0], w[2][1], w[2][2]);
        n_job.rd = (i_word.kind == KIND_READ);
        n_job.idx = i_word.cell_index;
        n_job.mass = i_word.particle_mass;
        n_job.hx = hx;
        n_job.hy = hy;
        n_job.hz = hz;
        n_job.wx0 = w[0][0]; n_job.wx1 = w[0][1]; n_job.wx2 = w[0][2];
        n_job.wy0 = w[1][0]; n_job.wy1 = w[1][1]; n_job.wy2 = w[1][2];
        n_job.wz0 = w[2][0]; n_job.wz1 = w[2][1]; n_job.wz2 = w[2][2];
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_job = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end
endmodule

>>> hdl/pmdg_queue.sv
// two-entry queue between front and back end
// depends on pmdg_pkg
module pmdg_queue import pmdg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);
    t_job r_mem[2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) r_mem[r_wp] <= i_job;
    end
endmodule

>>> hdl/pmdg_back.sv
// back end: clears the grid, then read-modify-writes 27 cells per deposit
// depends on pmdg_pkg; holds the cell memory
module pmdg_back import pmdg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_job      i_job,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);
    localparam logic [2:0] ST_CLR = 3'd0, ST_IDLE = 3'd1, ST_W1 = 3'd2,
                           ST_RD = 3'd4, ST_DONE = 3'd5;
    localparam int PIPE = 5;

    logic [47:0] r_mem[NCELLS];
    logic [2:0] r_st;
    logic [ADDR_W:0] r_clr;
    t_job r_job;
    logic [4:0] r_iss, r_cnt;
    logic [1:0] r_p, r_q, r_r;
    logic [PIPE-1:0] r_pv;
    logic [ADDR_W-1:0] r_pa[PIPE];
    logic [W_W-1:0] r_wxy, r_wz, r_wzd;
    logic [2*W_W-1:0] r_m1;
    logic [W_W-1:0] r_w;
    logic [W_W+31:0] r_m2;
    logic [47:0] r_add, r_rd, r_tot;
    t_out_word r_out;
    logic [W_W-1:0] wx, wy, wz;
    logic [SIDE_W-1:0] cx, cy, cz;
    logic [2*W_W-1:0] mw;
    logic [48:0] sum;
    logic [48:0] tsum;

    function automatic logic [SIDE_W-1:0] wrp(input logic [SIDE_W-1:0] c, input logic [1:0] k);
        begin
            case (k)
                2'd0: wrp = (c == '0) ? SIDE_W'(GRID_SIDE - 1) : c - 1'b1;
                2'd2: wrp = (c == SIDE_W'(GRID_SIDE - 1)) ? '0 : c + 1'b1;
                default: wrp = c;
            endcase
        end
    endfunction

    always_comb begin
        case (r_p)
            2'd0: wx = r_job.wx0;
            2'd1: wx = r_job.wx1;
            default: wx = r_job.wx2;
        endcase
        case (r_q)
            2'd0: wy = r_job.wy0;
            2'd1: wy = r_job.wy1;
            default: wy = r_job.wy2;
        endcase
        case (r_r)
            2'd0: wz = r_job.wz0;
            2'd1: wz = r_job.wz1;
            default: wz = r_job.wz2;
        endcase
        cx = wrp(r_job.hx, r_p);
        cy = wrp(r_job.hy, r_q);
        cz = wrp(r_job.hz, r_r);
        mw = (2*W_W)'(r_wxy) * (2*W_W)'(r_wzd) + ((2*W_W)'(1) << (WBITS - 1));
        sum = {1'b0, r_rd} + {1'b0, r_add};
        tsum = {1'b0, r_tot} + 49'(r_job.mass);
    end

    assign o_ready = (r_st == ST_IDLE);
    assign o_valid = (r_st == ST_DONE);
    assign o_word = r_out;

    // pipeline in order: issue wx*wy,wz  wxy  w  w*mass  add + read  write
    always_ff @(posedge i_clk) begin
        r_m1 <= (2*W_W)'(wx) * (2*W_W)'(wy) + ((2*W_W)'(1) << (WBITS - 1));
        r_wz <= wz;
        r_wzd <= r_wz;
        r_wxy <= W_W'(r_m1 >> WBITS);
        r_w <= W_W'(mw >> WBITS);
        r_m2 <= (W_W+32)'(r_w) * (W_W+32)'(r_job.mass) + ((W_W+32)'(1) << (WBITS - 1));
        r_add <= 48'(r_m2 >> WBITS);
        r_pa[0] <= {cx, cy, cz};
        for (int i = 1; i < PIPE; i++) r_pa[i] <= r_pa[i-1];
        r_rd <= r_mem[r_pa[PIPE-2]];
        if (r_st == ST_CLR) begin
            r_mem[r_clr[ADDR_W-1:0]] <= '0;
        end else if (r_pv[PIPE-1]) begin
            r_mem[r_pa[PIPE-1]] <= sum[48] ? MAX48 : sum[47:0];
        end
        if (r_st == ST_RD) begin
            r_out.cell_mass <= ({1'b0, r_job.idx} < 19'(NCELLS))
                               ? r_mem[r_job.idx[ADDR_W-1:0]] : '0;
            r_out.total_mass <= r_tot;
        end
        if (o_ready && i_valid) r_job <= i_job;
        if (!i_rst_n) begin
            r_st <= ST_CLR;
            r_clr <= '0;
            r_tot <= '0;
            r_pv <= '0;
            r_iss <= '0;
            r_cnt <= '0;
            r_p <= '0; r_q <= '0; r_r <= '0;
        end else begin
            r_pv <= {r_pv[PIPE-2:0], (r_st == ST_W1) && (r_iss != 5'd27)};
            unique case (r_st)
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (ADDR_W+1)'(NCELLS - 1)) r_st <= ST_IDLE;
                end
                ST_IDLE: if (i_valid) begin
                    r_p <= '0; r_q <= '0; r_r <= '0;
                    r_iss <= '0;
                    r_cnt <= '0;
                    r_st <= (i_job.rd) ? ST_RD : ST_W1;
                end
                ST_W1: begin
                    // one cell issued a cycle, then the pipeline drains
                    if (r_iss == 5'd27) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == 5'(PIPE)) begin
                            r_out.cell_mass <= '0;
                            r_out.total_mass <= tsum[48] ? MAX48 : tsum[47:0];
                            r_tot <= tsum[48] ? MAX48 : tsum[47:0];
                            r_st <= ST_DONE;
                        end
                    end else begin
                        r_iss <= r_iss + 1'b1;
                        if (r_r == 2'd2) begin
                            r_r <= '0;
                            if (r_q == 2'd2) begin
                                r_q <= '0;
                                r_p <= r_p + 1'b1;
                            end else begin
                                r_q <= r_q + 1'b1;
                            end
                        end else begin
                            r_r <= r_r + 1'b1;
                        end
                    end
                end
                ST_RD: r_st <= ST_DONE;
                ST_DONE: if (i_ready) r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> hdl/particle_mass_deposit_grid.sv
// particle mass deposit grid, top level
// depends on pmdg_pkg, pmdg_front, pmdg_queue, pmdg_back
//
// usage: input words arrive on i_in_valid/o_in_ready as t_in_word; a deposit
// word spreads its mass over the 27 cells around its home cell with
// cloud-in-cell or triangular-shaped-cloud weights, a read word returns one cell
// each input word gives one output word on o_out_valid/i_out_ready with the
// cell mass (zero for a deposit) and the running saturated total mass
// configuration: one-bit weight scheme written by i_cfg_valid/o_cfg_ready; the
// user must write it only while idle, which the block itself does not enforce
// operation: the front registers its result; per deposit the back end makes 27
// cell updates through the single memory port, then drains the five-stage
// weight pipeline; a read is answered from the memory directly
// reset: after reset the back end clears all 262144 cells, one a cycle, and
// takes no word until done; the front and the queue still fill
// stall: when the receiver holds i_out_ready low the result waits in the
// output register, the queue absorbs up to two classified words and the front
// register one more, then input ready drops
module particle_mass_deposit_grid import pmdg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);
    logic r_scheme;
    logic f_v, f_r, q_v, q_r;
    t_job f_job, q_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scheme <= 1'b0;
        end else if (i_cfg_valid) begin
            r_scheme <= i_cfg_data;
        end
    end

    pmdg_front u_front (
        .i_clk, .i_rst_n, .i_scheme(r_scheme),
        .i_valid(i_in_valid), .o_ready(o_in_ready), .i_word(i_in_word),
        .o_valid(f_v), .i_ready(f_r), .o_job(f_job)
    );

    pmdg_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_v), .o_ready(f_r), .i_job(f_job),
        .o_valid(q_v), .i_ready(q_r), .o_job(q_job)
    );

    pmdg_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_v), .o_ready(q_r), .i_job(q_job),
        .o_valid(o_out_valid), .i_ready(i_out_ready), .o_word(o_out_word)
    );
endmodule

>>> tb/sv/particle_mass_deposit_grid_tb.sv
// testbench for particle_mass_deposit_grid: random and directed deposit/read words
// checked against an in-bench mass grid predictor; depends on pmdg_pkg and the rtl
`timescale 1ns / 1ps

module particle_mass_deposit_grid_tb;
    import pmdg_pkg::*;

    localparam longint unsigned EDGE_POS = longint'(GRID_SIDE) << FRAC_BITS;
    localparam longint unsigned HALF_POS = 64'd1 << (FRAC_BITS - 1);
    localparam logic SCHEME_CIC = 1'b0;
    localparam logic SCHEME_TSC = 1'b1;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic      i_cfg_data;

    t_in_word    pending_words[$];
    t_out_word   expected_words[$];
    logic [47:0] grid_mass[int];
    logic [47:0] total_sum;
    logic        scheme;
    int          recent_homes[$];
    int          mismatches;
    bit          hold_send;
    bit          in_taken;
    int          burst_left;
    int          gap_left;
    int          stall_pct;
    int          stall_cnt;

    particle_mass_deposit_grid DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [47:0] add_sat48(logic [47:0] a, longint unsigned b);
        longint unsigned s;
        s = longint'(a) + b;
        return (s > longint'(MAX48)) ? MAX48 : s[47:0];
    endfunction

    function automatic longint unsigned round_tsc(longint unsigned v);
        return (v + (64'd1 << (2 * FRAC_BITS - WBITS)))
               >> (2 * FRAC_BITS + 1 - WBITS);
    endfunction

    function automatic void axis_weights(input logic [22:0] p, output int home,
                                         output longint unsigned w[3]);
        longint unsigned frac, a, lo, hi;
        bit neg;
        if (longint'(p) >= EDGE_POS) begin
            home = GRID_SIDE - 1;
            frac = 64'd1 << FRAC_BITS;
        end else begin
            home = int'(p >> FRAC_BITS);
            frac = p & ((64'd1 << FRAC_BITS) - 1);
        end
        neg = frac < HALF_POS;
        a = neg ? HALF_POS - frac : frac - HALF_POS;
        if (scheme == SCHEME_CIC) begin
            w[0] = (neg ? a : 0) << (WBITS - FRAC_BITS);
            w[1] = ((64'd1 << FRAC_BITS) - a) << (WBITS - FRAC_BITS);
            w[2] = (neg ? 0 : a) << (WBITS - FRAC_BITS);
        end else begin
            lo = neg ? HALF_POS + a : HALF_POS - a;
            hi = neg ? HALF_POS - a : HALF_POS + a;
            w[0] = round_tsc(lo * lo);
            w[1] = round_tsc((64'd3 << (2 * FRAC_BITS - 1)) - 2 * a * a);
            w[2] = round_tsc(hi * hi);
        end
    endfunction

    function automatic t_out_word deposit_or_read(t_in_word w);
        t_out_word r;
        longint unsigned wx[3], wy[3], wz[3];
        longint unsigned wxy, wt, add;
        int hx, hy, hz, cx, cy, cz, idx;
        if (w.kind == KIND_READ) begin
            idx = int'(w.cell_index);
            r.cell_mass = grid_mass.exists(idx) ? grid_mass[idx] : 48'd0;
            r.total_mass = total_sum;
            return r;
        end
        axis_weights(w.pos_x, hx, wx);
        axis_weights(w.pos_y, hy, wy);
        axis_weights(w.pos_z, hz, wz);
        total_sum = add_sat48(total_sum, w.particle_mass);
        for (int p = 0; p < 3; p++) begin
            cx = (hx + p - 1 + GRID_SIDE) % GRID_SIDE;
            for (int q = 0; q < 3; q++) begin
                cy = (hy + q - 1 + GRID_SIDE) % GRID_SIDE;
                wxy = (wx[p] * wy[q] + (64'd1 << (WBITS - 1))) >> WBITS;
                for (int s = 0; s < 3; s++) begin
                    cz = (hz + s - 1 + GRID_SIDE) % GRID_SIDE;
                    wt = (wxy * wz[s] + (64'd1 << (WBITS - 1))) >> WBITS;
                    add = (wt * longint'(w.particle_mass) + (64'd1 << (WBITS - 1))) >> WBITS;
                    idx = (cx * GRID_SIDE + cy) * GRID_SIDE + cz;
                    grid_mass[idx] = add_sat48(grid_mass.exists(idx) ? grid_mass[idx] : 48'd0,
                                               add);
                end
            end
        end
        r.cell_mass = '0;
        r.total_mass = total_sum;
        return r;
    endfunction

    // input side: predict on acceptance, then check results
    always @(posedge i_clk) begin
        t_out_word exp_w;
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            expected_words.push_back(deposit_or_read(i_in_word));
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", o_out_word);
            end else begin
                exp_w = expected_words.pop_front();
                if (o_out_word.cell_mass !== exp_w.cell_mass
                        || o_out_word.total_mass !== exp_w.total_mass) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: cell_mass exp %h got %h, total_mass exp %h got %h",
                                 exp_w.cell_mass, o_out_word.cell_mass,
                                 exp_w.total_mass, o_out_word.total_mass);
                end
            end
        end
    end

    // sender in bursts with gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_words.size() != 0 && !hold_send) begin
                i_in_word <= pending_words.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, the stall rate is redrawn each time its countdown expires
    always @(negedge i_clk) begin
        if (stall_cnt == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 30;
                2: stall_pct <= 70;
                default: stall_pct <= 95;
            endcase
            stall_cnt <= $urandom_range(100, 600);
        end else begin
            stall_cnt <= stall_cnt - 1;
        end
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic logic [22:0] rand_pos();
        case ($urandom_range(0, 9))
            0: return 23'(EDGE_POS);
            1: return 23'h7FFFFF - 23'($urandom_range(0, 1000));
            2: return 23'($urandom_range(0, GRID_SIDE - 1)) << FRAC_BITS;
            3: return (23'($urandom_range(0, GRID_SIDE - 1)) << FRAC_BITS) | 23'(HALF_POS);
            default: return 23'($urandom_range(0, int'(EDGE_POS) - 1));
        endcase
    endfunction

    function automatic t_in_word rand_deposit();
        t_in_word w;
        int hx, hy, hz;
        w = t_in_word'(120'({$urandom, $urandom, $urandom, $urandom}));
        w.kind = KIND_DEPOSIT;
        w.pos_x = rand_pos();
        w.pos_y = rand_pos();
        w.pos_z = rand_pos();
        case ($urandom_range(0, 5))
            0: w.particle_mass = 32'hFFFF_FFFF;
            1: w.particle_mass = $urandom_range(0, 255);
            default: w.particle_mass = $urandom;
        endcase
        hx = (longint'(w.pos_x) >= EDGE_POS) ? GRID_SIDE - 1 : int'(w.pos_x >> FRAC_BITS);
        hy = (longint'(w.pos_y) >= EDGE_POS) ? GRID_SIDE - 1 : int'(w.pos_y >> FRAC_BITS);
        hz = (longint'(w.pos_z) >= EDGE_POS) ? GRID_SIDE - 1 : int'(w.pos_z >> FRAC_BITS);
        recent_homes.push_back((hx * GRID_SIDE + hy) * GRID_SIDE + hz);
        if (recent_homes.size() > 16)
            void'(recent_homes.pop_front());
        return w;
    endfunction

    function automatic t_in_word read_word(int idx);
        t_in_word w;
        w = t_in_word'(120'({$urandom, $urandom, $urandom, $urandom}));
        w.kind = KIND_READ;
        w.cell_index = 18'(idx);
        return w;
    endfunction

    function automatic int near_cell();
        int h, x, y, z;
        if (recent_homes.size() == 0)
            return $urandom_range(0, NCELLS - 1);
        h = recent_homes[$urandom_range(0, recent_homes.size() - 1)];
        x = (h / (GRID_SIDE * GRID_SIDE) + $urandom_range(0, 2) - 1 + GRID_SIDE) % GRID_SIDE;
        y = ((h / GRID_SIDE) % GRID_SIDE + $urandom_range(0, 2) - 1 + GRID_SIDE) % GRID_SIDE;
        z = (h % GRID_SIDE + $urandom_range(0, 2) - 1 + GRID_SIDE) % GRID_SIDE;
        return (x * GRID_SIDE + y) * GRID_SIDE + z;
    endfunction

    task automatic wait_drained();
        while (pending_words.size() != 0 || i_in_valid || expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_scheme(logic value);
        wait_drained();
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        scheme = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic directed_words();
        t_in_word w;
        logic [22:0] edge_list[6];
        edge_list = '{23'd0, 23'(EDGE_POS), 23'h7FFFFF, 23'(HALF_POS),
                      23'(EDGE_POS - 1), 23'((3 << FRAC_BITS) + HALF_POS + 7)};
        for (int i = 0; i < 6; i++) begin
            w = read_word(0);
            w.kind = KIND_DEPOSIT;
            w.pos_x = edge_list[i];
            w.pos_y = edge_list[(i + 2) % 6];
            w.pos_z = edge_list[(i + 4) % 6];
            w.particle_mass = (i % 2) ? 32'hFFFF_FFFF : 32'd1000 * i;
            pending_words.push_back(w);
        end
        w.particle_mass = 32'd0;
        pending_words.push_back(w);
        pending_words.push_back(read_word(0));
        pending_words.push_back(read_word(NCELLS - 1));
        pending_words.push_back(read_word((GRID_SIDE - 1) * GRID_SIDE * GRID_SIDE));
        pending_words.push_back(read_word(GRID_SIDE - 1));
        pending_words.push_back(read_word(((GRID_SIDE - 2) * GRID_SIDE + 1) * GRID_SIDE));
    endtask

    task automatic random_words(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 6)
                pending_words.push_back(rand_deposit());
            else if ($urandom_range(0, 9) < 7)
                pending_words.push_back(read_word(near_cell()));
            else
                pending_words.push_back(read_word($urandom_range(0, NCELLS - 1)));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        total_sum = '0;
        scheme = SCHEME_CIC;
        mismatches = 0;
        hold_send = 1'b0;
        in_taken = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_pct = 0;
        stall_cnt = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_scheme(SCHEME_CIC);
        directed_words();
        random_words(300);
        wait (pending_words.size() < 150);
        hold_send = 1'b1;
        while (i_in_valid || expected_words.size() != 0)
            @(posedge i_clk);
        hold_send = 1'b0;

        write_scheme(SCHEME_TSC);
        directed_words();
        random_words(300);
        write_scheme(SCHEME_CIC);
        random_words(250);
        write_scheme(SCHEME_TSC);
        random_words(250);

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("particle_mass_deposit_grid regression: pass");
        else
            $display("particle_mass_deposit_grid regression: fail");
        $finish;
    end

    initial begin
        #40ms;
        $display("particle_mass_deposit_grid regression: fail");
        $finish;
    end
endmodule

>>> particle_mass_deposit_grid.f
hdl/pmdg_pkg.sv
hdl/pmdg_front.sv
hdl/pmdg_queue.sv
hdl/pmdg_back.sv
hdl/particle_mass_deposit_grid.sv
tb/sv/particle_mass_deposit_grid_tb.sv
